/* design/vector3_math_unit_core_assert.svh */
// Assertion macros used by the vector unit checker
`ifndef VECTOR3_MATH_UNIT_CORE_ASSERT_SVH
`define VECTOR3_MATH_UNIT_CORE_ASSERT_SVH

// Antecedent implies consequent on the same clock edge
`define VMU_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vmu check failed");

// Expression never true
`define VMU_ASSERT_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("vmu check failed");

`endif

/* design/vmu_pkg.sv */
// Shared constants, codes, types and helpers of the 3D vector unit
package vmu_pkg;
	localparam int FRAC_BITS = 16;
	localparam int W = 32;
	localparam int PW = 2 * W;
	localparam int XW = PW + 2;
	localparam int SQ_STAGES = W;
	localparam int QW = FRAC_BITS + 1;
	localparam int DVW = W + FRAC_BITS;
	localparam int RW = DVW + 1;
	localparam int LATENCY = 4 + SQ_STAGES + QW + 1;

	localparam logic [2:0] FN_ADD  = 3'd0;
	localparam logic [2:0] FN_SUB  = 3'd1;
	localparam logic [2:0] FN_SCL  = 3'd2;
	localparam logic [2:0] FN_DOT  = 3'd3;
	localparam logic [2:0] FN_CRS  = 3'd4;
	localparam logic [2:0] FN_LEN  = 3'd5;
	localparam logic [2:0] FN_NRM  = 3'd6;
	localparam logic [2:0] FN_DST  = 3'd7;

	localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

	typedef struct packed {
		logic [2:0]        func;
		logic [2:0][W-1:0] r;
		logic [W-1:0]      sc;
		logic              ov;
		logic [2:0][W-1:0] mag;
		logic [2:0]        neg;
	} carry_t;

	typedef struct packed {
		carry_t        c;
		logic [PW-1:0] rem;
		logic [W-1:0]  root;
	} sq_stage_t;

	typedef struct packed {
		carry_t             c;
		logic [W-1:0]       root;
		logic [2:0][RW-1:0] rem;
		logic [2:0][QW-1:0] q;
	} dv_stage_t;

	function automatic logic ovf32(input logic signed [XW-1:0] v);
		return (v > XW'(MAXV)) || (v < XW'(MINV));
	endfunction

	function automatic logic [W-1:0] sat32(input logic signed [XW-1:0] v);
		if (v > XW'(MAXV))
			return MAXV;
		else if (v < XW'(MINV))
			return MINV;
		else
			return v[W-1:0];
	endfunction
endpackage

/* design/vector3_math_unit_core.sv */
// Top level of the pipelined 3D fixed-point vector unit
//
// Usage:
//  - Present func, a_*, b_*, scale_factor and pulse start; an item is taken at
//    every edge where start is high and busy is low. busy is always low, so a
//    new item may enter in every cycle.
//  - Each item yields one result, shown for one cycle with done high, once it
//    has passed through the whole pipe. Order is preserved.
//  - The pipe is fixed length: 4 front stages (input, add/sub, multiply,
//    reduce), 32 square-root stages (one root bit each), a load register,
//    17 divide stages (one quotient bit each, three lanes for normalize)
//    and the output register. Every operation runs through the full pipe.
//  - Throughput is one item per cycle; the multiply stage uses six 32x32
//    multipliers shared among scale, dot, cross and squared length.
//  - The receiver cannot stall; results are never held back.
//  - Reset clears every valid bit; items in flight are dropped and done falls.
module vector3_math_unit_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [2:0]                  func,
	input  logic signed [vmu_pkg::W-1:0] a_x,
	input  logic signed [vmu_pkg::W-1:0] a_y,
	input  logic signed [vmu_pkg::W-1:0] a_z,
	input  logic signed [vmu_pkg::W-1:0] b_x,
	input  logic signed [vmu_pkg::W-1:0] b_y,
	input  logic signed [vmu_pkg::W-1:0] b_z,
	input  logic signed [vmu_pkg::W-1:0] scale_factor,
	output logic                        done,
	output logic signed [vmu_pkg::W-1:0] r_x,
	output logic signed [vmu_pkg::W-1:0] r_y,
	output logic signed [vmu_pkg::W-1:0] r_z,
	output logic signed [vmu_pkg::W-1:0] scalar_out,
	output logic                        overflow,
	output logic                        zero_length
);
	import vmu_pkg::*;

	// never stalls
	assign busy = 1'b0;

	// ---------------- stage 1: capture inputs ----------------
	logic              vld_s1;
	logic [2:0]        func_s1;
	logic signed [W-1:0] a_s1 [3];
	logic signed [W-1:0] b_s1 [3];
	logic signed [W-1:0] k_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else
			vld_s1 <= start;
	end

	always_ff @(posedge clk) begin
		func_s1 <= func;
		a_s1[0] <= a_x;
		a_s1[1] <= a_y;
		a_s1[2] <= a_z;
		b_s1[0] <= b_x;
		b_s1[1] <= b_y;
		b_s1[2] <= b_z;
		k_s1    <= scale_factor;
	end

	// ---------------- stage 2: add / subtract ----------------
	logic                vld_s2;
	logic [2:0]          func_s2;
	logic signed [W-1:0] a_s2 [3];
	logic signed [W-1:0] b_s2 [3];
	logic signed [W-1:0] v_s2 [3];
	logic signed [W-1:0] k_s2;
	logic [W-1:0]        r_s2 [3];
	logic                ov_s2;

	logic signed [XW-1:0] sum2 [3];
	logic signed [XW-1:0] dif2 [3];
	logic [W-1:0]         dsat2 [3];
	logic [W-1:0]         r2 [3];
	logic signed [W-1:0]  v2 [3];
	logic                 ov2;

	always_comb begin
		ov2 = 1'b0;
		for (int i = 0; i < 3; i++) begin
			sum2[i]  = XW'(a_s1[i]) + XW'(b_s1[i]);
			dif2[i]  = XW'(a_s1[i]) - XW'(b_s1[i]);
			dsat2[i] = sat32(dif2[i]);
			r2[i]    = '0;
			v2[i]    = a_s1[i];
			if (func_s1 == FN_ADD) begin
				r2[i] = sat32(sum2[i]);
				ov2   = ov2 | ovf32(sum2[i]);
			end
			if (func_s1 == FN_SUB) begin
				r2[i] = dsat2[i];
				ov2   = ov2 | ovf32(dif2[i]);
			end
			if (func_s1 == FN_DST) begin
				// length of the saturated difference
				v2[i] = dsat2[i];
				ov2   = ov2 | ovf32(dif2[i]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else
			vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		func_s2 <= func_s1;
		k_s2    <= k_s1;
		ov_s2   <= ov2;
		for (int i = 0; i < 3; i++) begin
			a_s2[i] <= a_s1[i];
			b_s2[i] <= b_s1[i];
			v_s2[i] <= v2[i];
			r_s2[i] <= r2[i];
		end
	end

	// ---------------- stage 3: shared multipliers ----------------
	logic                 vld_s3;
	logic signed [PW-1:0] p_s3 [6];
	carry_t               c_s3;

	logic signed [W-1:0] mx [6];
	logic signed [W-1:0] my [6];
	carry_t              c3;

	always_comb begin
		for (int j = 0; j < 6; j++) begin
			mx[j] = '0;
			my[j] = '0;
		end
		case (func_s2)
			FN_SCL: begin
				for (int j = 0; j < 3; j++) begin
					mx[j] = a_s2[j];
					my[j] = k_s2;
				end
			end
			FN_DOT: begin
				for (int j = 0; j < 3; j++) begin
					mx[j] = a_s2[j];
					my[j] = b_s2[j];
				end
			end
			FN_CRS: begin
				mx[0] = a_s2[1]; my[0] = b_s2[2];
				mx[1] = b_s2[1]; my[1] = a_s2[2];
				mx[2] = b_s2[0]; my[2] = a_s2[2];
				mx[3] = a_s2[0]; my[3] = b_s2[2];
				mx[4] = a_s2[0]; my[4] = b_s2[1];
				mx[5] = b_s2[0]; my[5] = a_s2[1];
			end
			default: begin
				// squares for length, normalize and distance
				for (int j = 0; j < 3; j++) begin
					mx[j] = v_s2[j];
					my[j] = v_s2[j];
				end
			end
		endcase

		c3.func = func_s2;
		c3.sc   = '0;
		c3.ov   = ov_s2;
		for (int i = 0; i < 3; i++) begin
			c3.r[i]   = r_s2[i];
			c3.neg[i] = a_s2[i][W-1];
			c3.mag[i] = a_s2[i][W-1] ? W'(-a_s2[i]) : W'(a_s2[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s3 <= 1'b0;
		else
			vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		c_s3 <= c3;
		for (int j = 0; j < 6; j++)
			p_s3[j] <= PW'(mx[j] * my[j]);
	end

	// ---------------- stage 4: reduce products ----------------
	logic                 vld_s4;
	sq_stage_t            sq4;
	logic signed [XW-1:0] red [3];
	logic signed [XW-1:0] dsum;

	always_comb begin
		sq4.c    = c_s3;
		sq4.root = '0;
		sq4.rem  = PW'(p_s3[0]) + PW'(p_s3[1]) + PW'(p_s3[2]);
		dsum     = XW'(p_s3[0]) + XW'(p_s3[1]) + XW'(p_s3[2]);
		red[0]   = (XW'(p_s3[0]) - XW'(p_s3[1])) >>> FRAC_BITS;
		red[1]   = (XW'(p_s3[2]) - XW'(p_s3[3])) >>> FRAC_BITS;
		red[2]   = (XW'(p_s3[4]) - XW'(p_s3[5])) >>> FRAC_BITS;
		case (c_s3.func)
			FN_SCL: begin
				for (int i = 0; i < 3; i++) begin
					sq4.c.r[i] = sat32(XW'(p_s3[i]) >>> FRAC_BITS);
					sq4.c.ov   = sq4.c.ov | ovf32(XW'(p_s3[i]) >>> FRAC_BITS);
				end
			end
			FN_DOT: begin
				sq4.c.sc = sat32(dsum >>> FRAC_BITS);
				sq4.c.ov = ovf32(dsum >>> FRAC_BITS);
			end
			FN_CRS: begin
				for (int i = 0; i < 3; i++) begin
					sq4.c.r[i] = sat32(red[i]);
					sq4.c.ov   = sq4.c.ov | ovf32(red[i]);
				end
			end
			default: begin
			end
		endcase
	end

	// ---------------- square root: one root bit per stage ----------------
	logic [SQ_STAGES:0] sq_vld;
	sq_stage_t          sq_s [SQ_STAGES+1];

	assign vld_s4 = vld_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sq_vld[0] <= 1'b0;
		else
			sq_vld[0] <= vld_s4;
	end

	always_ff @(posedge clk) begin
		sq_s[0] <= sq4;
	end

	for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
		localparam int BIT = SQ_STAGES - 1 - k;
		logic [XW-1:0] trial;
		sq_stage_t     nxt;

		always_comb begin
			trial = (XW'(sq_s[k].root) << (BIT + 1)) + (XW'(1) << (2 * BIT));
			nxt   = sq_s[k];
			if (XW'(sq_s[k].rem) >= trial) begin
				nxt.rem  = sq_s[k].rem - trial[PW-1:0];
				nxt.root = sq_s[k].root | (W'(1) << BIT);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				sq_vld[k+1] <= 1'b0;
			else
				sq_vld[k+1] <= sq_vld[k];
		end

		always_ff @(posedge clk) begin
			sq_s[k+1] <= nxt;
		end
	end

	// ---------------- divide: one quotient bit per stage, three lanes ----
	logic [QW:0] dv_vld;
	dv_stage_t   dv_s [QW+1];
	dv_stage_t   dv0;

	always_comb begin
		dv0.c    = sq_s[SQ_STAGES].c;
		dv0.root = sq_s[SQ_STAGES].root;
		for (int i = 0; i < 3; i++) begin
			dv0.rem[i] = RW'(sq_s[SQ_STAGES].c.mag[i]) << FRAC_BITS;
			dv0.q[i]   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dv_vld[0] <= 1'b0;
		else
			dv_vld[0] <= sq_vld[SQ_STAGES];
	end

	always_ff @(posedge clk) begin
		dv_s[0] <= dv0;
	end

	for (genvar k = 0; k < QW; k++) begin : g_div
		localparam int QB = QW - 1 - k;
		logic [RW-1:0] dsr;
		dv_stage_t     nxt;

		always_comb begin
			dsr = RW'(dv_s[k].root) << QB;
			nxt = dv_s[k];
			for (int i = 0; i < 3; i++) begin
				if (dv_s[k].rem[i] >= dsr) begin
					nxt.rem[i] = dv_s[k].rem[i] - dsr;
					nxt.q[i]   = dv_s[k].q[i] | (QW'(1) << QB);
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv_vld[k+1] <= 1'b0;
			else
				dv_vld[k+1] <= dv_vld[k];
		end

		always_ff @(posedge clk) begin
			dv_s[k+1] <= nxt;
		end
	end

	// ---------------- final select and output register ----------------
	dv_stage_t    fin;
	logic [W-1:0] o_r [3];
	logic [W-1:0] o_sc;
	logic         o_ov;
	logic         o_zl;
	logic [W-1:0] len_sat;

	assign fin     = dv_s[QW];
	assign len_sat = fin.root[W-1] ? MAXV : fin.root;

	always_comb begin
		for (int i = 0; i < 3; i++)
			o_r[i] = fin.c.r[i];
		o_sc = fin.c.sc;
		o_ov = fin.c.ov;
		o_zl = 1'b0;
		case (fin.c.func)
			FN_LEN, FN_DST: begin
				o_sc = len_sat;
				o_ov = fin.c.ov | fin.root[W-1];
			end
			FN_NRM: begin
				if (fin.root == '0) begin
					o_zl = 1'b1;
				end else begin
					for (int i = 0; i < 3; i++)
						o_r[i] = fin.c.neg[i] ? -W'(fin.q[i]) : W'(fin.q[i]);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done <= 1'b0;
		else
			done <= dv_vld[QW];
	end

	always_ff @(posedge clk) begin
		r_x         <= o_r[0];
		r_y         <= o_r[1];
		r_z         <= o_r[2];
		scalar_out  <= o_sc;
		overflow    <= o_ov;
		zero_length <= o_zl;
	end
endmodule

/* design/vmu_checker.sv */
// Port-level checker for the vector unit, bound to the top level
`include "vector3_math_unit_core_assert.svh"

module vmu_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        done,
	input logic signed [vmu_pkg::W-1:0] r_x,
	input logic signed [vmu_pkg::W-1:0] r_y,
	input logic signed [vmu_pkg::W-1:0] r_z,
	input logic signed [vmu_pkg::W-1:0] scalar_out,
	input logic                        zero_length
);
	import vmu_pkg::*;

	`VMU_ASSERT_NEVER(a_never_busy, busy)
	`VMU_ASSERT_IMPL(a_done_has_item, done, $past(start, LATENCY + 1))
	`VMU_ASSERT_IMPL(a_zl_zero_vec, done && zero_length, r_x == 0 && r_y == 0 && r_z == 0)
	`VMU_ASSERT_IMPL(a_scalar_no_vec, done && scalar_out != 0, r_x == 0 && r_y == 0 && r_z == 0)
endmodule

bind vector3_math_unit_core vmu_checker u_vmu_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.r_x(r_x),
	.r_y(r_y),
	.r_z(r_z),
	.scalar_out(scalar_out),
	.zero_length(zero_length)
);
